### design/lqrwb_pkg.sv
// ============================================================================
// lqrwb_pkg
// Shared types and constants for the wheel balance controller: stream field
// offsets, register indexes, controller states and control/status bundles.
// ============================================================================
package lqrwb_pkg;

    // Input stream layout, lowest bit first.
    localparam int IN_TDATA_W    = 160;
    localparam int OUT_TDATA_W   = 64;
    localparam int PITCH_LSB     = 0;
    localparam int RATE_LSB      = 32;
    localparam int LEFT_LSB      = 64;
    localparam int RIGHT_LSB     = 96;
    localparam int DT_LSB        = 128;
    localparam int HEIGHT_LSB    = 148;

    localparam int DATA_W        = 32;
    localparam int UDATA_W       = 31;
    localparam int DT_W          = 20;
    localparam int HEIGHT_W      = 9;
    localparam int CFG_INDEX_W   = 3;

    // Shared multiplier operand and product widths.
    localparam int MUL_W         = 33;
    localparam int PROD_W        = 2 * MUL_W;

    // Degrees to radians, pi/180 in Q0.32.
    localparam logic signed [MUL_W-1:0] DEG_TO_RAD_Q32 = 33'sd74961321;

    // Friction compensation: leg height and speed threshold (0.01 m/s).
    localparam logic [HEIGHT_W-1:0]     FRICTION_HEIGHT = 9'd290;
    localparam logic signed [DATA_W-1:0] FRICTION_EDGE  = 32'sd655;

    // Constant divider for microseconds to seconds.
    localparam int DIV_IN_W      = 52;
    localparam int DIV_Q_W       = 32;
    localparam int DIV_REM_W     = 20;
    localparam int DIV_BITS      = 4;
    localparam int DIV_STEPS     = DIV_Q_W / DIV_BITS;
    localparam int DIV_CNT_W     = $clog2(DIV_STEPS);
    localparam logic [DIV_REM_W:0]    US_PER_S     = 21'd1000000;
    localparam logic [DIV_IN_W-1:0]   HALF_US_PER_S = 52'd500000;

    // Configuration register indexes.
    typedef enum logic [CFG_INDEX_W-1:0] {
        REG_GAIN_PITCH      = 3'd0,
        REG_GAIN_PITCH_RATE = 3'd1,
        REG_GAIN_POSITION   = 3'd2,
        REG_GAIN_SPEED      = 3'd3,
        REG_WHEEL_RADIUS    = 3'd4,
        REG_DRIVE_LIMIT     = 3'd5,
        REG_POSITION_LIMIT  = 3'd6,
        REG_FRICTION_OFFSET = 3'd7
    } cfg_reg_t;

    // Operand pairs of the shared multiplier.
    typedef enum logic [2:0] {
        MUL_SPEED,
        MUL_PITCH,
        MUL_RATE,
        MUL_DT,
        MUL_GAIN_PITCH,
        MUL_GAIN_RATE,
        MUL_GAIN_SPEED,
        MUL_GAIN_POS
    } mul_sel_t;

    // Controller states, one per step of the schedule.
    typedef enum logic [3:0] {
        ST_IDLE,
        ST_SPEED,
        ST_PITCH,
        ST_RATE,
        ST_DT,
        ST_GAIN_PITCH,
        ST_GAIN_RATE,
        ST_GAIN_SPEED,
        ST_SUM_SPEED,
        ST_DIV_WAIT,
        ST_ACC,
        ST_GAIN_POS,
        ST_SUM_POS,
        ST_DRIVE
    } state_t;

    // Commands from the controller to the datapath.
    typedef struct packed {
        logic     load_in;
        logic     mul_en;
        mul_sel_t mul_sel;
        logic     save_speed;
        logic     save_pitch;
        logic     save_rate;
        logic     div_start;
        logic     sum_load;
        logic     sum_add;
        logic     acc_update;
        logic     load_out;
    } cmd_t;

    // Status from the datapath to the controller.
    typedef struct packed {
        logic div_busy;
        logic out_free;
    } status_t;

endpackage

### design/lqrwb_div.sv
// ============================================================================
// lqrwb_div
// Divides a 52-bit magnitude by one million. Restoring long division,
// four quotient bits per cycle.
// ============================================================================
module lqrwb_div (
    input  logic                          clk,
    input  logic                          rst_n,
    input  logic                          start,
    input  logic [lqrwb_pkg::DIV_IN_W-1:0] dividend,
    output logic                          busy,
    output logic [lqrwb_pkg::DIV_Q_W-1:0] quotient
);
    import lqrwb_pkg::*;

    logic [DIV_REM_W-1:0] rem_reg, rem_next;
    logic [DIV_Q_W-1:0]   qd_reg, qd_next;
    logic [DIV_CNT_W-1:0] cnt_reg;
    logic                 busy_reg;

    // Four restoring steps: shift in a dividend bit, subtract when it fits.
    always_comb
    begin
        logic [DIV_REM_W:0] trial;
        rem_next = rem_reg;
        qd_next  = qd_reg;
        for (int i = 0; i < DIV_BITS; i++)
        begin
            trial   = {rem_next, qd_next[DIV_Q_W-1]};
            qd_next = {qd_next[DIV_Q_W-2:0], 1'b0};
            if (trial >= US_PER_S)
            begin
                rem_next   = DIV_REM_W'(trial - US_PER_S);
                qd_next[0] = 1'b1;
            end
            else
            begin
                rem_next = trial[DIV_REM_W-1:0];
            end
        end
    end

    // Step counter and busy flag.
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            busy_reg <= 1'b0;
            cnt_reg  <= '0;
        end
        else if (start)
        begin
            busy_reg <= 1'b1;
            cnt_reg  <= DIV_CNT_W'(DIV_STEPS - 1);
        end
        else if (busy_reg)
        begin
            if (cnt_reg == '0)
            begin
                busy_reg <= 1'b0;
            end
            else
            begin
                cnt_reg <= cnt_reg - 1'b1;
            end
        end
    end

    // The quotient is below 2^32, so the top bits start below the divisor.
    always_ff @(posedge clk)
    begin
        if (start)
        begin
            rem_reg <= dividend[DIV_IN_W-1:DIV_Q_W];
            qd_reg  <= dividend[DIV_Q_W-1:0];
        end
        else if (busy_reg)
        begin
            rem_reg <= rem_next;
            qd_reg  <= qd_next;
        end
    end

    assign busy     = busy_reg;
    assign quotient = qd_reg;

endmodule

### design/lqrwb_ctrl.sv
// ============================================================================
// lqrwb_ctrl
// Sequencer for one control tick: schedules the shared multiplier, the
// constant divider and the accumulations, then hands off to the output.
// ============================================================================
module lqrwb_ctrl (
    input  logic               clk,
    input  logic               rst_n,
    input  logic               s_tvalid,
    output logic               s_tready,
    input  lqrwb_pkg::status_t status,
    output lqrwb_pkg::cmd_t    cmd
);
    import lqrwb_pkg::*;

    state_t state_reg, state_next;

    // State register.
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg <= ST_IDLE;
        end
        else
        begin
            state_reg <= state_next;
        end
    end

    // Next state.
    always_comb
    begin
        state_next = state_reg;
        case (state_reg)
            ST_IDLE:
            begin
                if (s_tvalid)
                begin
                    state_next = ST_SPEED;
                end
            end
            ST_SPEED:      state_next = ST_PITCH;
            ST_PITCH:      state_next = ST_RATE;
            ST_RATE:       state_next = ST_DT;
            ST_DT:         state_next = ST_GAIN_PITCH;
            ST_GAIN_PITCH: state_next = ST_GAIN_RATE;
            ST_GAIN_RATE:  state_next = ST_GAIN_SPEED;
            ST_GAIN_SPEED: state_next = ST_SUM_SPEED;
            ST_SUM_SPEED:  state_next = ST_DIV_WAIT;
            ST_DIV_WAIT:
            begin
                if (!status.div_busy)
                begin
                    state_next = ST_ACC;
                end
            end
            ST_ACC:        state_next = ST_GAIN_POS;
            ST_GAIN_POS:   state_next = ST_SUM_POS;
            ST_SUM_POS:    state_next = ST_DRIVE;
            ST_DRIVE:
            begin
                if (status.out_free)
                begin
                    state_next = ST_IDLE;
                end
            end
            default:       state_next = ST_IDLE;
        endcase
    end

    // Commands for the datapath.
    always_comb
    begin
        cmd         = '0;
        cmd.mul_sel = MUL_SPEED;
        s_tready    = 1'b0;
        case (state_reg)
            ST_IDLE:
            begin
                s_tready    = 1'b1;
                cmd.load_in = s_tvalid;
            end
            ST_SPEED:
            begin
                cmd.mul_en  = 1'b1;
                cmd.mul_sel = MUL_SPEED;
            end
            ST_PITCH:
            begin
                cmd.save_speed = 1'b1;
                cmd.mul_en     = 1'b1;
                cmd.mul_sel    = MUL_PITCH;
            end
            ST_RATE:
            begin
                cmd.save_pitch = 1'b1;
                cmd.mul_en     = 1'b1;
                cmd.mul_sel    = MUL_RATE;
            end
            ST_DT:
            begin
                cmd.save_rate = 1'b1;
                cmd.mul_en    = 1'b1;
                cmd.mul_sel   = MUL_DT;
            end
            ST_GAIN_PITCH:
            begin
                cmd.div_start = 1'b1;
                cmd.mul_en    = 1'b1;
                cmd.mul_sel   = MUL_GAIN_PITCH;
            end
            ST_GAIN_RATE:
            begin
                cmd.sum_load = 1'b1;
                cmd.mul_en   = 1'b1;
                cmd.mul_sel  = MUL_GAIN_RATE;
            end
            ST_GAIN_SPEED:
            begin
                cmd.sum_add = 1'b1;
                cmd.mul_en  = 1'b1;
                cmd.mul_sel = MUL_GAIN_SPEED;
            end
            ST_SUM_SPEED:
            begin
                cmd.sum_add = 1'b1;
            end
            ST_DIV_WAIT:
            begin
                cmd.acc_update = 1'b0;
            end
            ST_ACC:
            begin
                cmd.acc_update = 1'b1;
            end
            ST_GAIN_POS:
            begin
                cmd.mul_en  = 1'b1;
                cmd.mul_sel = MUL_GAIN_POS;
            end
            ST_SUM_POS:
            begin
                cmd.sum_add = 1'b1;
            end
            ST_DRIVE:
            begin
                cmd.load_out = status.out_free;
            end
            default:
            begin
                cmd.load_in = 1'b0;
            end
        endcase
    end

endmodule

### design/lqrwb_datapath.sv
// ============================================================================
// lqrwb_datapath
// Configuration registers, input registers, the shared multiplier with its
// product register, rounding and saturation, the displacement accumulator
// and the output register.
// ============================================================================
module lqrwb_datapath (
    input  logic                               clk,
    input  logic                               rst_n,
    input  lqrwb_pkg::cmd_t                    cmd,
    output lqrwb_pkg::status_t                 status,
    input  logic [lqrwb_pkg::IN_TDATA_W-1:0]   s_tdata,
    output logic                               m_tvalid,
    input  logic                               m_tready,
    output logic [lqrwb_pkg::OUT_TDATA_W-1:0]  m_tdata,
    input  logic                               cfg_valid,
    input  logic                               cfg_ready,
    input  logic [lqrwb_pkg::CFG_INDEX_W-1:0]  cfg_index,
    input  logic [lqrwb_pkg::DATA_W-1:0]       cfg_data
);
    import lqrwb_pkg::*;

    // Configuration registers.
    logic signed [DATA_W-1:0] gain_pitch_reg, gain_rate_reg, gain_pos_reg, gain_speed_reg;
    logic [UDATA_W-1:0]       radius_reg, drive_limit_reg, pos_limit_reg, friction_reg;

    // Per-tick registers.
    logic signed [MUL_W-1:0]  wsum_reg;
    logic signed [DATA_W-1:0] pitch_reg, rate_reg;
    logic [DT_W-1:0]          dt_reg;
    logic [HEIGHT_W-1:0]      height_reg;
    logic signed [DATA_W-1:0] speed_reg;
    logic signed [MUL_W-1:0]  pitch_rad_reg, rate_rad_reg;
    logic signed [PROD_W-1:0] prod_reg;
    logic                     neg_reg;
    logic signed [50:0]       sum_reg;
    logic signed [DATA_W-1:0] acc_reg;
    logic signed [DATA_W-1:0] drive_out_reg, disp_out_reg;
    logic                     out_valid_reg;

    // Combinational helpers.
    logic signed [MUL_W-1:0]  mul_a, mul_b;
    logic signed [PROD_W-1:0] spd_round, rad_round, term_round;
    logic signed [49:0]       spd_neg;
    logic signed [DATA_W-1:0] speed_sat;
    logic signed [49:0]       term;
    logic [DIV_IN_W-1:0]      div_dividend;
    logic                     div_busy;
    logic [DIV_Q_W-1:0]       div_quotient;
    logic signed [33:0]       acc_sum, pos_lim, pos_lim_neg;
    logic signed [DATA_W-1:0] fric;
    logic signed [51:0]       drv, drv_lim, drv_lim_neg;
    logic signed [DATA_W-1:0] drive_sat;

    // Configuration writes; indexes past the list do not occur with this width.
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            gain_pitch_reg  <= -32'sd485619;
            gain_rate_reg   <= -32'sd206818;
            gain_pos_reg    <= -32'sd46341;
            gain_speed_reg  <= -32'sd242950;
            radius_reg      <= 31'd4588;
            drive_limit_reg <= 31'd655360;
            pos_limit_reg   <= 31'd6554;
            friction_reg    <= 31'd13107;
        end
        else if (cfg_valid && cfg_ready)
        begin
            case (cfg_index)
                REG_GAIN_PITCH:      gain_pitch_reg  <= cfg_data;
                REG_GAIN_PITCH_RATE: gain_rate_reg   <= cfg_data;
                REG_GAIN_POSITION:   gain_pos_reg    <= cfg_data;
                REG_GAIN_SPEED:      gain_speed_reg  <= cfg_data;
                REG_WHEEL_RADIUS:    radius_reg      <= cfg_data[UDATA_W-1:0];
                REG_DRIVE_LIMIT:     drive_limit_reg <= cfg_data[UDATA_W-1:0];
                REG_POSITION_LIMIT:  pos_limit_reg   <= cfg_data[UDATA_W-1:0];
                REG_FRICTION_OFFSET: friction_reg    <= cfg_data[UDATA_W-1:0];
                default:             gain_pitch_reg  <= gain_pitch_reg;
            endcase
        end
    end

    // Input capture; the wheel speeds are summed on the way in.
    always_ff @(posedge clk)
    begin
        if (cmd.load_in)
        begin
            pitch_reg  <= s_tdata[PITCH_LSB +: DATA_W];
            rate_reg   <= s_tdata[RATE_LSB +: DATA_W];
            wsum_reg   <= $signed({s_tdata[LEFT_LSB + DATA_W - 1], s_tdata[LEFT_LSB +: DATA_W]})
                        + $signed({s_tdata[RIGHT_LSB + DATA_W - 1], s_tdata[RIGHT_LSB +: DATA_W]});
            dt_reg     <= s_tdata[DT_LSB +: DT_W];
            height_reg <= s_tdata[HEIGHT_LSB +: HEIGHT_W];
        end
    end

    // Operand selection for the shared multiplier.
    always_comb
    begin
        mul_a = wsum_reg;
        mul_b = $signed({2'b00, radius_reg});
        case (cmd.mul_sel)
            MUL_SPEED:
            begin
                mul_a = wsum_reg;
                mul_b = $signed({2'b00, radius_reg});
            end
            MUL_PITCH:
            begin
                mul_a = MUL_W'(pitch_reg);
                mul_b = DEG_TO_RAD_Q32;
            end
            MUL_RATE:
            begin
                mul_a = MUL_W'(rate_reg);
                mul_b = DEG_TO_RAD_Q32;
            end
            MUL_DT:
            begin
                mul_a = MUL_W'(speed_reg);
                mul_b = $signed({13'd0, dt_reg});
            end
            MUL_GAIN_PITCH:
            begin
                mul_a = MUL_W'(gain_pitch_reg);
                mul_b = pitch_rad_reg;
            end
            MUL_GAIN_RATE:
            begin
                mul_a = MUL_W'(gain_rate_reg);
                mul_b = rate_rad_reg;
            end
            MUL_GAIN_SPEED:
            begin
                mul_a = MUL_W'(gain_speed_reg);
                mul_b = MUL_W'(speed_reg);
            end
            MUL_GAIN_POS:
            begin
                mul_a = MUL_W'(gain_pos_reg);
                mul_b = MUL_W'(acc_reg);
            end
            default:
            begin
                mul_a = wsum_reg;
                mul_b = $signed({2'b00, radius_reg});
            end
        endcase
    end

    // Product register.
    always_ff @(posedge clk)
    begin
        if (cmd.mul_en)
        begin
            prod_reg <= mul_a * mul_b;
        end
    end

    // Ground speed: negated, rounded by 2^17, saturated to 32 bits.
    always_comb
    begin
        spd_round = prod_reg + PROD_W'(66'sd65536);
        spd_neg   = 50'sd0 - $signed({spd_round[PROD_W-1], spd_round[PROD_W-1:17]});
        if (spd_neg > 50'sd2147483647)
        begin
            speed_sat = 32'sh7fffffff;
        end
        else if (spd_neg < -50'sd2147483648)
        begin
            speed_sat = 32'sh80000000;
        end
        else
        begin
            speed_sat = spd_neg[DATA_W-1:0];
        end
    end

    // Degrees to radians, rounded by 2^32; the result is well inside 33 bits.
    assign rad_round = prod_reg + PROD_W'(66'sd2147483648);

    // Gain products rounded by 2^16.
    assign term_round = prod_reg + PROD_W'(66'sd32768);
    assign term       = term_round[PROD_W-1:16];

    always_ff @(posedge clk)
    begin
        if (cmd.save_speed)
        begin
            speed_reg <= speed_sat;
        end
        if (cmd.save_pitch)
        begin
            pitch_rad_reg <= rad_round[64:32];
        end
        if (cmd.save_rate)
        begin
            rate_rad_reg <= rad_round[64:32];
        end
        if (cmd.sum_load)
        begin
            sum_reg <= 51'(term);
        end
        else if (cmd.sum_add)
        begin
            sum_reg <= sum_reg + 51'(term);
        end
        if (cmd.div_start)
        begin
            neg_reg <= prod_reg[PROD_W-1];
        end
    end

    // Magnitude of speed*dt plus half a million, for round half away from zero.
    assign div_dividend = prod_reg[PROD_W-1]
                        ? (~prod_reg[DIV_IN_W-1:0] + HALF_US_PER_S + 52'd1)
                        : (prod_reg[DIV_IN_W-1:0] + HALF_US_PER_S);

    lqrwb_div u_div (
        .clk      (clk),
        .rst_n    (rst_n),
        .start    (cmd.div_start),
        .dividend (div_dividend),
        .busy     (div_busy),
        .quotient (div_quotient)
    );

    // Displacement update with symmetric clamp.
    always_comb
    begin
        if (neg_reg)
        begin
            acc_sum = 34'(acc_reg) - $signed({2'b00, div_quotient});
        end
        else
        begin
            acc_sum = 34'(acc_reg) + $signed({2'b00, div_quotient});
        end
        pos_lim     = $signed({3'b000, pos_limit_reg});
        pos_lim_neg = 34'sd0 - pos_lim;
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            acc_reg <= '0;
        end
        else if (cmd.acc_update)
        begin
            if (acc_sum > pos_lim)
            begin
                acc_reg <= pos_lim[DATA_W-1:0];
            end
            else if (acc_sum < pos_lim_neg)
            begin
                acc_reg <= pos_lim_neg[DATA_W-1:0];
            end
            else
            begin
                acc_reg <= acc_sum[DATA_W-1:0];
            end
        end
    end

    // Friction term at the friction leg height; a speed of exactly 0.01 m/s takes minus.
    always_comb
    begin
        fric = '0;
        if (height_reg == FRICTION_HEIGHT)
        begin
            if (speed_reg > FRICTION_EDGE)
            begin
                fric = $signed({1'b0, friction_reg});
            end
            else if (speed_reg != '0)
            begin
                fric = 32'sd0 - $signed({1'b0, friction_reg});
            end
        end
    end

    // Negated sum plus friction, saturated to the drive limit.
    always_comb
    begin
        drv         = 52'sd0 - 52'(sum_reg) + 52'(fric);
        drv_lim     = $signed({21'd0, drive_limit_reg});
        drv_lim_neg = 52'sd0 - drv_lim;
        if (drv > drv_lim)
        begin
            drive_sat = drv_lim[DATA_W-1:0];
        end
        else if (drv < drv_lim_neg)
        begin
            drive_sat = drv_lim_neg[DATA_W-1:0];
        end
        else
        begin
            drive_sat = drv[DATA_W-1:0];
        end
    end

    // Output register; holds until the result is taken.
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            out_valid_reg <= 1'b0;
        end
        else if (cmd.load_out)
        begin
            out_valid_reg <= 1'b1;
        end
        else if (m_tready)
        begin
            out_valid_reg <= 1'b0;
        end
    end

    always_ff @(posedge clk)
    begin
        if (cmd.load_out)
        begin
            drive_out_reg <= drive_sat;
            disp_out_reg  <= acc_reg;
        end
    end

    assign m_tvalid        = out_valid_reg;
    assign m_tdata         = {disp_out_reg, drive_out_reg};
    assign status.div_busy = div_busy;
    assign status.out_free = !out_valid_reg || m_tready;

endmodule

### design/lqr_wheel_balance_controller_top.sv
// Inputs are taken only in the idle state, so a tick ends before the next input is accepted.
// The tick schedule is set by the shared 33x33 multiplier (eight products per tick)
// and the constant divider for the tick displacement (four bits per cycle).
// A pending result in the output register does not block the next input.
// Reset (rst_n, asynchronous, active low) restores the register defaults,
// clears the displacement accumulator and empties the output register.
// ============================================================================
// lqr_wheel_balance_controller_top
// Two-wheel balance controller: state feedback on pitch, pitch rate,
// integrated displacement and ground speed, with friction compensation.
// ============================================================================
module lqr_wheel_balance_controller_top (
    input  logic                               clk,
    input  logic                               rst_n,
    // Slave stream: pitch_deg, pitch_rate_dps, left_wheel_speed,
    // right_wheel_speed, elapsed_us, leg_height, zero pad (lowest bit first).
    input  logic                               s_tvalid,
    output logic                               s_tready,
    input  logic [lqrwb_pkg::IN_TDATA_W-1:0]   s_tdata,
    // Master stream: wheel_drive, displacement (lowest bit first).
    output logic                               m_tvalid,
    input  logic                               m_tready,
    output logic [lqrwb_pkg::OUT_TDATA_W-1:0]  m_tdata,
    // Configuration write channel.
    input  logic                               cfg_valid,
    output logic                               cfg_ready,
    input  logic [lqrwb_pkg::CFG_INDEX_W-1:0]  cfg_index,
    input  logic [lqrwb_pkg::DATA_W-1:0]       cfg_data
);
    import lqrwb_pkg::*;

    cmd_t    cmd;
    status_t status;

    // Register writes are always taken.
    assign cfg_ready = 1'b1;

    lqrwb_ctrl u_ctrl (
        .clk      (clk),
        .rst_n    (rst_n),
        .s_tvalid (s_tvalid),
        .s_tready (s_tready),
        .status   (status),
        .cmd      (cmd)
    );

    lqrwb_datapath u_datapath (
        .clk       (clk),
        .rst_n     (rst_n),
        .cmd       (cmd),
        .status    (status),
        .s_tdata   (s_tdata),
        .m_tvalid  (m_tvalid),
        .m_tready  (m_tready),
        .m_tdata   (m_tdata),
        .cfg_valid (cfg_valid),
        .cfg_ready (cfg_ready),
        .cfg_index (cfg_index),
        .cfg_data  (cfg_data)
    );

endmodule
